// ===== rtl/sfd_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the sync frame deframer.
package sfd_pkg;

  localparam int unsigned TickCountBits = 16;
  localparam int unsigned TimeoutBits   = 16;

  localparam logic [7:0]  SyncByte   = 8'hAA;
  localparam logic [7:0]  SyncZero   = 8'h00;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam logic [15:0] TimeoutRst = 16'd1000;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_CRC_GOOD = 2'd1,
    KIND_CRC_BAD  = 2'd2,
    KIND_ABORT    = 2'd3
  } kind_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] len;
  } res_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/sfd_core.sv =====
// Frame receive state machine: sync hunt, length, payload, CRC check and timeout.
module sfd_core import sfd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  item_t                  item_i,
  input  logic [TimeoutBits-1:0] tick_limit_i,
  output res_t                   res_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SYNC1  = 3'd1,
    PH_SYNC2  = 3'd2,
    PH_LEN    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_CRC_HI = 3'd6
  } phase_e;

  localparam logic [TickCountBits-1:0] TickMax = '1;

  phase_e                   phase_q, phase_d;
  logic [TickCountBits-1:0] tick_q, tick_d;
  logic [7:0]               len_q, len_d;
  logic [8:0]               pos_q, pos_d;
  logic [15:0]              crc_q, crc_d;
  logic [7:0]               crc_lo_q, crc_lo_d;

  logic [7:0]  c;
  logic [15:0] crc_got;
  logic [8:0]  pos_inc;

  assign c       = item_i.rx_byte;
  assign crc_got = {c, crc_lo_q};
  assign pos_inc = pos_q + 9'd1;

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    len_d      = len_q;
    pos_d      = pos_q;
    crc_d      = crc_q;
    crc_lo_d   = crc_lo_q;
    res_o      = '0;
    res_o.kind = KIND_PAYLOAD;
    res_o.len  = len_q;
    if (step_i) begin
      if (item_i.opcode == OP_TICK) begin
        if (phase_q != PH_IDLE) begin
          if (tick_q != TickMax) begin
            tick_d = tick_q + 1'b1;
          end
          if (32'(tick_d) > 32'(tick_limit_i)) begin
            phase_d = PH_IDLE;
            if (pos_q != '0) begin
              res_o.valid = 1'b1;
              res_o.kind  = KIND_ABORT;
            end
          end
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (c == SyncByte) begin
              phase_d = PH_SYNC1;
              tick_d  = '0;
              pos_d   = '0;
            end
          end
          PH_SYNC1: phase_d = (c == SyncByte) ? PH_SYNC2 : PH_IDLE;
          PH_SYNC2: phase_d = (c == SyncZero) ? PH_LEN : PH_IDLE;
          PH_LEN: begin
            len_d   = c;
            pos_d   = '0;
            crc_d   = crc16_byte(CrcInit, c);
            phase_d = (c == 8'd0) ? PH_CRC_LO : PH_DATA;
          end
          PH_DATA: begin
            crc_d = crc16_byte(crc_q, c);
            pos_d = pos_inc;
            if (pos_inc >= {1'b0, len_q}) begin
              phase_d = PH_CRC_LO;
            end
            res_o.valid = 1'b1;
            res_o.data  = c;
          end
          PH_CRC_LO: begin
            crc_lo_d = c;
            phase_d  = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            phase_d     = PH_IDLE;
            res_o.valid = 1'b1;
            res_o.kind  = (crc_got == crc_q) ? KIND_CRC_GOOD : KIND_CRC_BAD;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      crc_q    <= CrcInit;
      crc_lo_q <= '0;
    end else begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

// ===== rtl/sync_frame_deframer_crc16.sv =====
// Top level of the sync frame deframer with Modbus CRC-16 check.
//
//  channel | signals                                         | transfer when
//  in      | in_valid_i, in_ready_o, opcode_i, rx_byte_i     | in_valid_i & in_ready_o
//  out     | out_valid_o, out_ready_i, result_kind_o,        | out_valid_o & out_ready_i
//          | data_byte_o, frame_length_o                     |
//  cfg     | cfg_we_i, cfg_wdata_i (tick limit)              | cfg_we_i
//
// One item per cycle sustained unless the output stalls; each item waits in the input
// register until processed; its result, if any, is captured in the output register.
// The combinational CRC byte update between input and result registers sets the rate.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled output holds the input register; input ready drops once it is full.
module sync_frame_deframer_crc16 import sfd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   opcode_i,
  input  logic [7:0]             rx_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             result_kind_o,
  output logic [7:0]             data_byte_o,
  output logic [7:0]             frame_length_o,
  input  logic                   cfg_we_i,
  input  logic [TimeoutBits-1:0] cfg_wdata_i
);

  logic [TimeoutBits-1:0] tick_limit_q;
  logic                   in_vld_q;
  item_t                  in_item_q;
  logic                   out_vld_q;
  res_t                   out_res_q;
  res_t                   res;
  logic                   advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  sfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_item_q),
    .tick_limit_i (tick_limit_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_limit_q <= TimeoutRst;
    end else if (cfg_we_i) begin
      tick_limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q.opcode  <= opcode_e'(opcode_i);
      in_item_q.rx_byte <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.valid;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_kind_o  = out_res_q.kind;
  assign data_byte_o    = out_res_q.data;
  assign frame_length_o = out_res_q.len;

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o != KIND_PAYLOAD) |-> data_byte_o == 8'd0)
    else $error("nonzero data byte on a frame end or abort result");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a blocked output");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_ready_i) |=> (in_vld_q && $stable(in_item_q)))
    else $error("input register changed while output stalled");

endmodule

// ===== verif/sync_frame_deframer_crc16_checker.sv =====
// Deframer checker: predicts each result from the input transfers and compares it.
`timescale 1ns / 1ps
module sync_frame_deframer_crc16_checker import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  result_kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  frame_length_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    HUNT,
    SEEN_SYNC1,
    SEEN_SYNC2,
    WANT_LEN,
    IN_PAYLOAD,
    WANT_CRC_LO,
    WANT_CRC_HI
  } rx_phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] len;
  } frame_event_t;

  frame_event_t expected_q[$];
  rx_phase_e    phase;
  logic [15:0]  tick_limit;
  logic [15:0]  ticks;
  logic [15:0]  crc_acc;
  logic [7:0]   open_len;
  logic [7:0]   crc_lo;
  logic [8:0]   rx_pos;
  int           errors;

  function automatic logic [15:0] crc16_fold(logic [15:0] acc, logic [7:0] octet);
    logic [15:0] r;
    r = acc ^ {8'h00, octet};
    repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CrcPoly) : {1'b0, r[15:1]};
    return r;
  endfunction

  task automatic note_event(kind_e kind, logic [7:0] data);
    frame_event_t ev;
    ev.kind = kind;
    ev.data = data;
    ev.len  = open_len;
    expected_q.push_back(ev);
  endtask

  task automatic track_item(logic op, logic [7:0] b);
    logic [15:0] got;
    if (op == OP_TICK) begin
      if (phase != HUNT) begin
        if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
        if (ticks > tick_limit) begin
          phase = HUNT;
          if (rx_pos != 9'd0) note_event(KIND_ABORT, 8'h00);
        end
      end
    end else begin
      case (phase)
        HUNT: begin
          if (b == SyncByte) begin
            phase  = SEEN_SYNC1;
            ticks  = 16'd0;
            rx_pos = 9'd0;
          end
        end
        SEEN_SYNC1: phase = (b == SyncByte) ? SEEN_SYNC2 : HUNT;
        SEEN_SYNC2: phase = (b == SyncZero) ? WANT_LEN : HUNT;
        WANT_LEN: begin
          open_len = b;
          rx_pos   = 9'd0;
          crc_acc  = crc16_fold(CrcInit, b);
          phase    = (b == 8'd0) ? WANT_CRC_LO : IN_PAYLOAD;
        end
        IN_PAYLOAD: begin
          crc_acc = crc16_fold(crc_acc, b);
          rx_pos  = rx_pos + 9'd1;
          if (rx_pos >= {1'b0, open_len}) phase = WANT_CRC_LO;
          note_event(KIND_PAYLOAD, b);
        end
        WANT_CRC_LO: begin
          crc_lo = b;
          phase  = WANT_CRC_HI;
        end
        WANT_CRC_HI: begin
          got   = {b, crc_lo};
          phase = HUNT;
          note_event((got == crc_acc) ? KIND_CRC_GOOD : KIND_CRC_BAD, 8'h00);
        end
        default: phase = HUNT;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_event_t want;
    if (!rst_ni) begin
      expected_q.delete();
      phase        = HUNT;
      tick_limit   = TimeoutRst;
      ticks        = 16'd0;
      crc_acc      = CrcInit;
      open_len     = 8'd0;
      crc_lo       = 8'd0;
      rx_pos       = 9'd0;
      errors       = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: unexpected result kind %0d data %02h len %0d", $time,
                     result_kind_i, data_byte_i, frame_length_i);
          end
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (result_kind_i !== want.kind || data_byte_i !== want.data ||
              frame_length_i !== want.len) begin
            if (errors < 10) begin
              $display("%0t: expected kind %0d data %02h len %0d, got kind %0d data %02h len %0d",
                       $time, want.kind, want.data, want.len,
                       result_kind_i, data_byte_i, frame_length_i);
            end
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) track_item(opcode_i, rx_byte_i);
      if (cfg_we_i) tick_limit = cfg_wdata_i;
      mismatches_o <= errors;
      pending_o    <= expected_q.size();
    end
  end

endmodule

// ===== verif/sync_frame_deframer_crc16_test.sv =====
// Deframer testbench top: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module sync_frame_deframer_crc16_test;
  import sfd_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  data_byte_o;
  logic [7:0]  frame_length_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  int          mismatches;
  int          pending;
  bit          calm = 1'b0;
  int          stall_left = 0;
  int unsigned fed_items = 0;
  int unsigned cur_timeout = TimeoutRst;

  sync_frame_deframer_crc16 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .data_byte_o   (data_byte_o),
    .frame_length_o(frame_length_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  sync_frame_deframer_crc16_checker frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .opcode_i      (opcode_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_i (result_kind_o),
    .data_byte_i   (data_byte_o),
    .frame_length_i(frame_length_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 9);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic push_item(logic op, logic [7:0] b, bit counted);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (counted) fed_items++;
  endtask

  task automatic maybe_ticks(int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      repeat ($urandom_range(1, 3)) push_item(OP_TICK, 8'($urandom), 1'b1);
    end
  endtask

  // header, length, body and CRC low byte first; park ticks sit before the CRC
  task automatic send_frame(octet_q_t body, bit spoil, int unsigned tick_pct,
                            int unsigned park);
    logic [15:0] crc;
    crc = crc16_byte(CrcInit, 8'(body.size()));
    push_item(OP_BYTE, SyncByte, 1'b1);
    maybe_ticks(tick_pct);
    push_item(OP_BYTE, SyncByte, 1'b1);
    maybe_ticks(tick_pct);
    push_item(OP_BYTE, SyncZero, 1'b1);
    maybe_ticks(tick_pct);
    push_item(OP_BYTE, 8'(body.size()), 1'b1);
    maybe_ticks(tick_pct);
    foreach (body[i]) begin
      crc = crc16_byte(crc, body[i]);
      push_item(OP_BYTE, body[i], 1'b1);
      maybe_ticks(tick_pct);
    end
    repeat (park) push_item(OP_TICK, 8'($urandom), 1'b1);
    if (spoil) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    push_item(OP_BYTE, crc[7:0], 1'b1);
    maybe_ticks(tick_pct);
    push_item(OP_BYTE, crc[15:8], 1'b1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timeout(logic [15:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_timeout = value;
  endtask

  initial begin
    octet_q_t    body;
    logic [15:0] plan [5];
    logic [7:0]  x;
    int unsigned goal;
    int unsigned n;
    int unsigned pick;
    int unsigned park;
    bit          paused;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    opcode_i    <= OP_BYTE;
    rx_byte_i   <= 8'h00;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 16'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, both sync mismatches, zero length, extremes, bad CRC
    push_item(OP_TICK, 8'hFF, 1'b0);
    push_item(OP_BYTE, SyncByte, 1'b1);
    push_item(OP_BYTE, SyncByte, 1'b1);
    push_item(OP_BYTE, SyncByte, 1'b1);
    push_item(OP_BYTE, SyncByte, 1'b1);
    push_item(OP_BYTE, SyncZero, 1'b1);
    body.delete();
    send_frame(body, 1'b0, 0, 0);
    body = {8'hFF};
    send_frame(body, 1'b0, 0, 0);
    body = {8'h00, 8'hFF};
    send_frame(body, 1'b1, 0, 0);

    // zero timeout: silent drop before payload, abort after it
    set_timeout(16'd0);
    push_item(OP_BYTE, SyncByte, 1'b1);
    push_item(OP_TICK, 8'h00, 1'b1);
    body = {8'h5A, 8'h3C};
    send_frame(body, 1'b0, 0, 1);

    // longest frame under the widest timeout
    set_timeout(16'hFFFF);
    calm <= 1'b1;
    body.delete();
    repeat (255) body.push_back(8'($urandom));
    send_frame(body, 1'b0, 0, 20);
    calm <= 1'b0;

    plan = '{16'd0, 16'($urandom_range(1, 40)), 16'hFFFF, 16'($urandom_range(41, 400)),
             TimeoutRst};
    for (int p = 0; p < 5; p++) begin
      set_timeout(plan[p]);
      if (p == 4) calm <= 1'b1;
      goal   = fed_items + 110;
      paused = 1'b0;
      while (fed_items < goal) begin
        if (p == 2 && !paused && fed_items + 55 >= goal) begin
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          n = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 12);
          body.delete();
          repeat (n) body.push_back(8'($urandom));
          park = 0;
          if (cur_timeout <= 300 && $urandom_range(0, 4) == 0) begin
            park = $urandom_range(0, cur_timeout + 2);
          end
          send_frame(body, $urandom_range(0, 3) == 0, $urandom_range(0, 2) * 15, park);
        end else if (pick < 85) begin
          x = 8'($urandom);
          push_item(OP_BYTE, SyncByte, 1'b1);
          if ($urandom_range(0, 1) == 0) begin
            if (x == SyncByte) x = x ^ 8'h01;
          end else begin
            push_item(OP_BYTE, SyncByte, 1'b1);
            if (x == SyncZero) x = x ^ 8'h80;
          end
          push_item(OP_BYTE, x, 1'b1);
        end else if (pick < 95) begin
          repeat ($urandom_range(1, 6)) begin
            x = ($urandom_range(0, 2) == 0) ? SyncByte : 8'($urandom);
            push_item(OP_BYTE, x, 1'b1);
          end
        end else begin
          repeat ($urandom_range(1, 4)) push_item(OP_TICK, 8'($urandom), 1'b0);
        end
      end
    end

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
